/* sv/amc_pkg.sv */
`default_nettype none
package amc_pkg;

  localparam int ADDR_W    = 10;
  localparam int MEM_WORDS = 1 << ADDR_W;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = ADDR_W;

  // command codes
  localparam logic [CMD_W-1:0] CMD_MEM_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXECUTE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_PC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SP = 1'd1;

  typedef enum logic [4:0] {
    OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_XOR, OP_AND, OP_OR, OP_JMP,
    OP_JPG, OP_JPE, OP_JPL, OP_JPNE, OP_PUSH, OP_POP, OP_CALL, OP_RET,
    OP_READ, OP_WRITE, OP_HALT
  } opcode_e;

  // microcode step addresses; sequential runs must stay adjacent
  typedef enum logic [4:0] {
    S_IDLE,
    S_MEMWR,
    S_RESTART,
    S_FETCH,
    S_DECODE,
    S_OPND,
    S_EA,
    S_ALU,
    S_STORE,
    S_BRANCH,
    S_PUSH,
    S_POP_RD,
    S_POP_WR,
    S_CALL,
    S_READ,
    S_WRITE,
    S_RET_RD,
    S_RET,
    S_HALT,
    S_DONE
  } step_e;

  typedef enum logic [2:0] {
    SEQ_NEXT, SEQ_JUMP, SEQ_ACCEPT, SEQ_DISP_CLASS, SEQ_DISP_OP, SEQ_RETIRE
  } seq_e;

  typedef enum logic [2:0] {
    ADDR_PC, ADDR_EA_NEW, ADDR_EA, ADDR_SP, ADDR_SPM1, ADDR_CMD
  } addr_sel_e;

  typedef enum logic [2:0] {
    WD_ACC, WD_RDATA, WD_PC, WD_READ, WD_CMD
  } wdata_sel_e;

  typedef enum logic [2:0] {
    PC_KEEP, PC_INC, PC_BRANCH, PC_EA, PC_RDATA, PC_START
  } pc_op_e;

  typedef enum logic [1:0] {
    SP_KEEP, SP_DEC, SP_INC, SP_START
  } sp_op_e;

  typedef enum logic [1:0] {
    ACC_KEEP, ACC_ALU, ACC_CLR
  } acc_op_e;

  typedef enum logic [1:0] {
    HALT_KEEP, HALT_SET, HALT_CLR
  } halt_op_e;

  typedef struct packed {
    seq_e       seq;
    step_e      target;
    addr_sel_e  addr_sel;
    logic       mem_we;
    wdata_sel_e wdata_sel;
    pc_op_e     pc_op;
    sp_op_e     sp_op;
    acc_op_e    acc_op;
    halt_op_e   halt_op;
    logic       ld_op;
    logic       ld_ea;
    logic       print;
    logic       read_take;
  } ucode_t;

  typedef struct packed {
    logic              clr_busy;
    logic              halted;
    logic              print_valid;
    logic [DATA_W-1:0] print_value;
    logic              read_taken;
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] sp;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] mem_rdata;
    opcode_e           op;
  } status_t;

  function automatic ucode_t ucode_rom(step_e s);
    ucode_t w;
    w        = '0;
    w.seq    = SEQ_JUMP;
    w.target = S_DONE;
    case (s)
      S_IDLE:    w.seq = SEQ_ACCEPT;
      S_MEMWR: begin
        w.addr_sel  = ADDR_CMD;
        w.mem_we    = 1'b1;
        w.wdata_sel = WD_CMD;
      end
      S_RESTART: begin
        w.pc_op   = PC_START;
        w.sp_op   = SP_START;
        w.acc_op  = ACC_CLR;
        w.halt_op = HALT_CLR;
      end
      S_FETCH: begin
        w.seq      = SEQ_NEXT;
        w.addr_sel = ADDR_PC;
        w.pc_op    = PC_INC;
      end
      S_DECODE: begin
        w.seq   = SEQ_DISP_CLASS;
        w.ld_op = 1'b1;
      end
      S_OPND: begin
        w.seq      = SEQ_NEXT;
        w.addr_sel = ADDR_PC;
        w.pc_op    = PC_INC;
      end
      S_EA: begin
        w.seq      = SEQ_DISP_OP;
        w.addr_sel = ADDR_EA_NEW;
        w.ld_ea    = 1'b1;
      end
      S_ALU:     w.acc_op = ACC_ALU;
      S_STORE: begin
        w.addr_sel  = ADDR_EA;
        w.mem_we    = 1'b1;
        w.wdata_sel = WD_ACC;
      end
      S_BRANCH:  w.pc_op = PC_BRANCH;
      S_PUSH: begin
        w.addr_sel  = ADDR_SPM1;
        w.mem_we    = 1'b1;
        w.wdata_sel = WD_RDATA;
        w.sp_op     = SP_DEC;
      end
      S_POP_RD: begin
        w.seq      = SEQ_NEXT;
        w.addr_sel = ADDR_SP;
      end
      S_POP_WR: begin
        w.addr_sel  = ADDR_EA;
        w.mem_we    = 1'b1;
        w.wdata_sel = WD_RDATA;
        w.sp_op     = SP_INC;
      end
      S_CALL: begin
        w.addr_sel  = ADDR_SPM1;
        w.mem_we    = 1'b1;
        w.wdata_sel = WD_PC;
        w.sp_op     = SP_DEC;
        w.pc_op     = PC_EA;
      end
      S_READ: begin
        w.addr_sel  = ADDR_EA;
        w.mem_we    = 1'b1;
        w.wdata_sel = WD_READ;
        w.read_take = 1'b1;
      end
      S_WRITE:   w.print = 1'b1;
      S_RET_RD: begin
        w.seq      = SEQ_NEXT;
        w.addr_sel = ADDR_SP;
      end
      S_RET: begin
        w.pc_op = PC_RDATA;
        w.sp_op = SP_INC;
      end
      S_HALT:    w.halt_op = HALT_SET;
      S_DONE:    w.seq = SEQ_RETIRE;
      default:   w.seq = SEQ_JUMP;
    endcase
    return w;
  endfunction

  function automatic step_e cmd_entry(logic [CMD_W-1:0] cmd, logic halted);
    step_e s;
    s = S_DONE;
    case (cmd)
      CMD_MEM_WRITE: s = S_MEMWR;
      CMD_RESTART:   s = S_RESTART;
      CMD_EXECUTE:   s = halted ? S_DONE : S_FETCH;
      default:       s = S_DONE;
    endcase
    return s;
  endfunction

  // opcode word -> first step; unknown opcodes have only consumed the opcode word
  function automatic step_e decode_class(logic [DATA_W-1:0] w);
    step_e s;
    s = S_DONE;
    if (w[DATA_W-1:5] == '0) begin
      if (w[4:0] == OP_RET)       s = S_RET_RD;
      else if (w[4:0] == OP_HALT) s = S_HALT;
      else if (w[4:0] <= OP_WRITE) s = S_OPND;
    end
    return s;
  endfunction

  function automatic step_e op_dispatch(opcode_e op);
    step_e s;
    s = S_DONE;
    case (op)
      OP_LOAD, OP_ADD, OP_SUB, OP_XOR, OP_AND, OP_OR: s = S_ALU;
      OP_STORE:                                     s = S_STORE;
      OP_JMP, OP_JPG, OP_JPE, OP_JPL, OP_JPNE:      s = S_BRANCH;
      OP_PUSH:                                      s = S_PUSH;
      OP_POP:                                       s = S_POP_RD;
      OP_CALL:                                      s = S_CALL;
      OP_READ:                                      s = S_READ;
      OP_WRITE:                                     s = S_WRITE;
      default:                                      s = S_DONE;
    endcase
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] alu(opcode_e op, logic [DATA_W-1:0] acc,
                                            logic [DATA_W-1:0] m);
    logic [DATA_W-1:0] r;
    r = acc;
    case (op)
      OP_LOAD: r = m;
      OP_ADD:  r = acc + m;
      OP_SUB:  r = acc - m;
      OP_XOR:  r = acc ^ m;
      OP_AND:  r = acc & m;
      OP_OR:   r = acc | m;
      default: r = acc;
    endcase
    return r;
  endfunction

  function automatic logic branch_taken(opcode_e op, logic [DATA_W-1:0] acc);
    logic t;
    t = 1'b0;
    case (op)
      OP_JMP:  t = 1'b1;
      OP_JPG:  t = !acc[DATA_W-1] && (acc != '0);
      OP_JPE:  t = (acc == '0);
      OP_JPL:  t = acc[DATA_W-1];
      OP_JPNE: t = (acc != '0);
      default: t = 1'b0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

/* sv/amc_cmd_if.sv */
`default_nettype none
interface amc_cmd_if;
  logic                               valid;
  logic                               ready;
  logic        [amc_pkg::CMD_W-1:0]  command;
  logic        [amc_pkg::ADDR_W-1:0] mem_address;
  logic signed [amc_pkg::DATA_W-1:0] mem_data;
  logic signed [amc_pkg::DATA_W-1:0] read_value;

  modport source (output valid, command, mem_address, mem_data, read_value, input ready);
  modport sink   (input valid, command, mem_address, mem_data, read_value, output ready);
endinterface
`default_nettype wire

/* sv/amc_res_if.sv */
`default_nettype none
interface amc_res_if;
  logic                               valid;
  logic                               ready;
  logic                               halted;
  logic                               print_valid;
  logic signed [amc_pkg::DATA_W-1:0] print_value;
  logic                               read_taken;
  logic        [amc_pkg::ADDR_W-1:0] pc_now;
  logic        [amc_pkg::ADDR_W-1:0] sp_now;
  logic signed [amc_pkg::DATA_W-1:0] acc_now;

  modport source (output valid, halted, print_valid, print_value, read_taken, pc_now, sp_now,
                  acc_now, input ready);
  modport sink   (input valid, halted, print_valid, print_value, read_taken, pc_now, sp_now,
                  acc_now, output ready);
endinterface
`default_nettype wire

/* sv/amc_datapath.sv */
`default_nettype none
module amc_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire amc_pkg::ucode_t                 uc_i,
  input  wire logic                            start_i,
  input  wire logic [amc_pkg::ADDR_W-1:0]      mem_address_i,
  input  wire logic [amc_pkg::DATA_W-1:0]      mem_data_i,
  input  wire logic [amc_pkg::DATA_W-1:0]      read_value_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [amc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [amc_pkg::CFG_W-1:0]       cfg_wdata_i,
  output amc_pkg::status_t                     status_o
);

  logic [amc_pkg::DATA_W-1:0] mem_q [amc_pkg::MEM_WORDS];
  logic [amc_pkg::DATA_W-1:0] rdata_q;

  logic [amc_pkg::ADDR_W-1:0] pc_q, pc_d, sp_q, sp_d;
  logic [amc_pkg::DATA_W-1:0] acc_q, acc_d;
  logic                       halt_q, halt_d;
  amc_pkg::opcode_e           op_q;
  logic [amc_pkg::ADDR_W-1:0] ea_q;
  logic [amc_pkg::ADDR_W-1:0] cmd_addr_q;
  logic [amc_pkg::DATA_W-1:0] cmd_data_q, read_val_q;
  logic                       pv_q, rt_q;
  logic [amc_pkg::DATA_W-1:0] pval_q;
  logic [amc_pkg::ADDR_W-1:0] start_pc_q, start_sp_q;
  logic                       clr_busy_q;
  logic [amc_pkg::ADDR_W-1:0] clr_cnt_q;

  logic [amc_pkg::ADDR_W-1:0] ea_new, mem_addr;
  logic [amc_pkg::DATA_W-1:0] mem_wdata;
  logic                       mem_we;

  // PC already points past the operand word when the operand lands in rdata
  assign ea_new = pc_q + rdata_q[amc_pkg::ADDR_W-1:0];

  always_comb begin
    case (uc_i.addr_sel)
      amc_pkg::ADDR_PC:     mem_addr = pc_q;
      amc_pkg::ADDR_EA_NEW: mem_addr = ea_new;
      amc_pkg::ADDR_EA:     mem_addr = ea_q;
      amc_pkg::ADDR_SP:     mem_addr = sp_q;
      amc_pkg::ADDR_SPM1:   mem_addr = sp_q - amc_pkg::ADDR_W'(1);
      amc_pkg::ADDR_CMD:    mem_addr = cmd_addr_q;
      default:              mem_addr = pc_q;
    endcase
    case (uc_i.wdata_sel)
      amc_pkg::WD_ACC:   mem_wdata = acc_q;
      amc_pkg::WD_RDATA: mem_wdata = rdata_q;
      amc_pkg::WD_PC:    mem_wdata = {{(amc_pkg::DATA_W-amc_pkg::ADDR_W){1'b0}}, pc_q};
      amc_pkg::WD_READ:  mem_wdata = read_val_q;
      amc_pkg::WD_CMD:   mem_wdata = cmd_data_q;
      default:           mem_wdata = acc_q;
    endcase
    mem_we = uc_i.mem_we;
    if (clr_busy_q) begin
      mem_addr  = clr_cnt_q;
      mem_wdata = '0;
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

  always_comb begin
    case (uc_i.pc_op)
      amc_pkg::PC_INC:    pc_d = pc_q + amc_pkg::ADDR_W'(1);
      amc_pkg::PC_BRANCH: pc_d = amc_pkg::branch_taken(op_q, acc_q) ? ea_q : pc_q;
      amc_pkg::PC_EA:     pc_d = ea_q;
      amc_pkg::PC_RDATA:  pc_d = rdata_q[amc_pkg::ADDR_W-1:0];
      amc_pkg::PC_START:  pc_d = start_pc_q;
      default:            pc_d = pc_q;
    endcase
    case (uc_i.sp_op)
      amc_pkg::SP_DEC:   sp_d = sp_q - amc_pkg::ADDR_W'(1);
      amc_pkg::SP_INC:   sp_d = sp_q + amc_pkg::ADDR_W'(1);
      amc_pkg::SP_START: sp_d = start_sp_q;
      default:           sp_d = sp_q;
    endcase
    case (uc_i.acc_op)
      amc_pkg::ACC_ALU: acc_d = amc_pkg::alu(op_q, acc_q, rdata_q);
      amc_pkg::ACC_CLR: acc_d = '0;
      default:          acc_d = acc_q;
    endcase
    case (uc_i.halt_op)
      amc_pkg::HALT_SET: halt_d = 1'b1;
      amc_pkg::HALT_CLR: halt_d = 1'b0;
      default:           halt_d = halt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= '0;
      sp_q       <= '0;
      acc_q      <= '0;
      halt_q     <= 1'b0;
      pv_q       <= 1'b0;
      rt_q       <= 1'b0;
      pval_q     <= '0;
      start_pc_q <= '0;
      start_sp_q <= '0;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      pc_q   <= pc_d;
      sp_q   <= sp_d;
      acc_q  <= acc_d;
      halt_q <= halt_d;
      if (start_i) begin
        pv_q   <= 1'b0;
        rt_q   <= 1'b0;
        pval_q <= '0;
      end else begin
        if (uc_i.print) begin
          pv_q   <= 1'b1;
          pval_q <= rdata_q;
        end
        if (uc_i.read_take) begin
          rt_q <= 1'b1;
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          amc_pkg::CFG_START_PC: start_pc_q <= cfg_wdata_i;
          amc_pkg::CFG_START_SP: start_sp_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + amc_pkg::ADDR_W'(1);
        if (clr_cnt_q == amc_pkg::ADDR_W'(amc_pkg::MEM_WORDS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (uc_i.ld_op) begin
      op_q <= amc_pkg::opcode_e'(rdata_q[4:0]);
    end
    if (uc_i.ld_ea) begin
      ea_q <= ea_new;
    end
    if (start_i) begin
      cmd_addr_q <= mem_address_i;
      cmd_data_q <= mem_data_i;
      read_val_q <= read_value_i;
    end
  end

  always_comb begin
    status_o.clr_busy    = clr_busy_q;
    status_o.halted      = halt_q;
    status_o.print_valid = pv_q;
    status_o.print_value = pval_q;
    status_o.read_taken  = rt_q;
    status_o.pc          = pc_q;
    status_o.sp          = sp_q;
    status_o.acc         = acc_q;
    status_o.mem_rdata   = rdata_q;
    status_o.op          = op_q;
  end

endmodule
`default_nettype wire

/* sv/accumulator_machine_core.sv */
// Accumulator machine core.
// cmd (sink): one transaction per command: write a memory word, execute one
//   instruction, or restart from start_pc/start_sp. res (source): exactly one
//   transaction per command with halt flag, WRITE output, READ consumption and
//   the PC, SP and accumulator after the command.
// start_pc/start_sp are written through cfg_we_i/cfg_index_i/cfg_wdata_i.
// A microcode sequencer walks one control word per cycle, save while it waits
// in idle or in its final step, over a single-port 1024-word memory with
// registered read data, so each memory access costs a step. An unknown command,
// or execute while halted, goes straight to the final step; memory write and
// restart run their own step first; an instruction runs fetch and decode, then
// stops (unknown opcode), runs HALT, runs the RET read and RET, or runs operand,
// effective address and its own step (POP: read, then write). After reset the
// memory is swept to zero, one word per cycle; cmd.ready stays low meanwhile
// while config writes are still taken. A finished result sits in an output
// register; the next command is accepted back in idle and run while it waits,
// and holds in its final step until res.ready frees it.
`default_nettype none
module accumulator_machine_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [amc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [amc_pkg::CFG_W-1:0]     cfg_wdata_i,
  amc_cmd_if.sink                            cmd,
  amc_res_if.source                          res
);

  amc_pkg::step_e   step_q, step_d;
  amc_pkg::ucode_t  uc;
  amc_pkg::status_t st;
  logic             accept, retire;

  logic                       res_valid_q;
  logic                       res_halted_q, res_pv_q, res_rt_q;
  logic [amc_pkg::DATA_W-1:0] res_pval_q, res_acc_q;
  logic [amc_pkg::ADDR_W-1:0] res_pc_q, res_sp_q;

  amc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .uc_i          (uc),
    .start_i       (accept),
    .mem_address_i (cmd.mem_address),
    .mem_data_i    (cmd.mem_data),
    .read_value_i  (cmd.read_value),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .status_o      (st)
  );

  // control word and handshake
  always_comb begin
    uc        = amc_pkg::ucode_rom(step_q);
    cmd.ready = (step_q == amc_pkg::S_IDLE) && !st.clr_busy;
    accept    = cmd.valid && cmd.ready;
    retire    = (step_q == amc_pkg::S_DONE) && (!res_valid_q || res.ready);
  end

  // step sequencing
  always_comb begin
    case (uc.seq)
      amc_pkg::SEQ_NEXT:       step_d = amc_pkg::step_e'(step_q + 5'd1);
      amc_pkg::SEQ_JUMP:       step_d = uc.target;
      amc_pkg::SEQ_ACCEPT:     step_d = accept ? amc_pkg::cmd_entry(cmd.command, st.halted)
                                               : amc_pkg::S_IDLE;
      amc_pkg::SEQ_DISP_CLASS: step_d = amc_pkg::decode_class(st.mem_rdata);
      amc_pkg::SEQ_DISP_OP:    step_d = amc_pkg::op_dispatch(st.op);
      amc_pkg::SEQ_RETIRE:     step_d = retire ? amc_pkg::S_IDLE : amc_pkg::S_DONE;
      default:                 step_d = amc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= amc_pkg::S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (retire) begin
        res_valid_q <= 1'b1;
      end else if (res.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire) begin
      res_halted_q <= st.halted;
      res_pv_q     <= st.print_valid;
      res_pval_q   <= st.print_value;
      res_rt_q     <= st.read_taken;
      res_pc_q     <= st.pc;
      res_sp_q     <= st.sp;
      res_acc_q    <= st.acc;
    end
  end

  assign res.valid       = res_valid_q;
  assign res.halted      = res_halted_q;
  assign res.print_valid = res_pv_q;
  assign res.print_value = res_pval_q;
  assign res.read_taken  = res_rt_q;
  assign res.pc_now      = res_pc_q;
  assign res.sp_now      = res_sp_q;
  assign res.acc_now     = res_acc_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (step_q != amc_pkg::S_IDLE))
    else $error("sequencer stayed idle after an accepted transaction");

  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.clr_busy |-> !res_valid_q)
    else $error("result presented during memory clear");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(step_q == amc_pkg::S_DONE))
    else $error("result raised outside the final step");

  a_halted_no_io: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_halted_q) |-> (!res_pv_q && !res_rt_q))
    else $error("halted result carries WRITE or READ activity");

  a_print_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_pv_q) |-> (res_pval_q == '0))
    else $error("print value nonzero without WRITE");

endmodule
`default_nettype wire
